// ----- hw/rtl/lru_keyed_cache_with_generation_unit_defines.svh -----
// ----------------------------------------------------------------------------
// LRU keyed cache - assertion macros
// Shared concurrent assertion wrappers, clocked on the rising edge and
// disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef LRU_KEYED_CACHE_WITH_GENERATION_UNIT_DEFINES_SVH
`define LRU_KEYED_CACHE_WITH_GENERATION_UNIT_DEFINES_SVH

// Same-cycle implication.
`define LKC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LKC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/lkc_pkg.sv -----
// ----------------------------------------------------------------------------
// LRU keyed cache - package
// Widths, codes and shared types of the keyed cache.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lkc_pkg;

  localparam int unsigned ENTRIES_DEF = 8;
  localparam int unsigned KEY_W       = 64;
  localparam int unsigned GEN_W       = 32;
  localparam int unsigned HDL_W       = 32;
  localparam int unsigned STAMP_W     = 64;
  localparam int unsigned SLOT_W      = 6;

  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_STORE  = 1'b1;

  typedef enum logic [2:0] {
    STAT_HIT      = 3'd0,
    STAT_MISS     = 3'd1,
    STAT_STORED   = 3'd2,
    STAT_DECLINED = 3'd3,
    STAT_BADGEN   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_FIN
  } state_e;

  typedef struct packed {
    logic               func;
    logic [KEY_W-1:0]   host_key;
    logic [GEN_W-1:0]   generation;
    logic [HDL_W-1:0]   value_handle;
    logic               parse_ok;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [HDL_W-1:0]   value_out;
    logic [SLOT_W-1:0]  slot_index;
  } rsp_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [GEN_W-1:0]   generation;
    logic [HDL_W-1:0]   handle;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  // stamp_we: touch only; entry_we: full slot write, sets valid
  typedef struct packed {
    logic stamp_we;
    logic entry_we;
  } wr_cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lkc_table.sv -----
// ----------------------------------------------------------------------------
// LRU keyed cache - slot table
// Slot memory with one read and one write port, registered read data,
// and per-slot valid flops cleared by reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lkc_table #(
  parameter int unsigned Entries = lkc_pkg::ENTRIES_DEF,
  parameter int unsigned IdxW    = (Entries > 1) ? $clog2(Entries) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             rd_en_i,
  input  wire logic [IdxW-1:0]  rd_addr_i,
  output lkc_pkg::entry_t       rd_entry_o,
  output logic                  rd_valid_o,
  input  wire lkc_pkg::wr_cmd_t wr_cmd_i,
  input  wire logic [IdxW-1:0]  wr_addr_i,
  input  wire lkc_pkg::entry_t  wr_entry_i
);

  logic [lkc_pkg::KEY_W-1:0]   key_mem   [Entries];
  logic [lkc_pkg::GEN_W-1:0]   gen_mem   [Entries];
  logic [lkc_pkg::HDL_W-1:0]   hdl_mem   [Entries];
  logic [lkc_pkg::STAMP_W-1:0] stamp_mem [Entries];
  logic [Entries-1:0]          valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_cmd_i.entry_we) begin
      key_mem[wr_addr_i] <= wr_entry_i.key;
      gen_mem[wr_addr_i] <= wr_entry_i.generation;
      hdl_mem[wr_addr_i] <= wr_entry_i.handle;
    end
    if (wr_cmd_i.entry_we || wr_cmd_i.stamp_we) begin
      stamp_mem[wr_addr_i] <= wr_entry_i.stamp;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_entry_o.key        <= key_mem[rd_addr_i];
      rd_entry_o.generation <= gen_mem[rd_addr_i];
      rd_entry_o.handle     <= hdl_mem[rd_addr_i];
      rd_entry_o.stamp      <= stamp_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_o <= 1'b0;
    end else begin
      if (wr_cmd_i.entry_we) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_o <= valid_q[rd_addr_i];
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/lkc_ctrl.sv -----
// ----------------------------------------------------------------------------
// LRU keyed cache - scan sequencer
// Walks the slots one a cycle through a shared key/stamp comparator,
// then resolves hit, store slot and touch clock in one final step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lkc_ctrl #(
  parameter int unsigned Entries = lkc_pkg::ENTRIES_DEF,
  parameter int unsigned IdxW    = (Entries > 1) ? $clog2(Entries) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire lkc_pkg::req_t    req_i,
  input  wire logic             req_valid_i,
  output logic                  req_ready_o,
  output lkc_pkg::rsp_t         res_o,
  output logic                  res_valid_o,
  input  wire logic             res_ready_i,
  output logic                  rd_en_o,
  output logic [IdxW-1:0]       rd_addr_o,
  input  wire lkc_pkg::entry_t  rd_entry_i,
  input  wire logic             rd_valid_i,
  output lkc_pkg::wr_cmd_t      wr_cmd_o,
  output logic [IdxW-1:0]       wr_addr_o,
  output lkc_pkg::entry_t       wr_entry_o
);

  localparam logic [IdxW-1:0] LastIdx = IdxW'(Entries - 1);

  lkc_pkg::state_e state_q, state_d;
  lkc_pkg::req_t   req_q;

  logic [IdxW-1:0] iss_q, iss_d;
  logic            cmp_vld_q, cmp_vld_d;
  logic [IdxW-1:0] cmp_idx_q;

  logic                        match_found_q;
  logic [IdxW-1:0]             match_idx_q;
  logic [lkc_pkg::GEN_W-1:0]   match_gen_q;
  logic [lkc_pkg::HDL_W-1:0]   match_hdl_q;
  logic                        free_found_q;
  logic [IdxW-1:0]             free_idx_q;
  logic                        lru_found_q;
  logic [IdxW-1:0]             lru_idx_q;
  logic [lkc_pkg::STAMP_W-1:0] lru_stamp_q;
  logic [lkc_pkg::STAMP_W-1:0] clock_q, clock_d, clock_inc;

  logic accept, commit;
  logic key_eq, stamp_lt;
  logic upd_match, upd_free, upd_lru;
  logic gen_zero, hit;
  logic [IdxW-1:0] store_idx;

  assign accept    = req_valid_i && req_ready_o;
  assign commit    = res_valid_o && res_ready_i;

  // shared comparator on the slot read last cycle
  assign key_eq    = rd_entry_i.key == req_q.host_key;
  assign stamp_lt  = rd_entry_i.stamp < lru_stamp_q;
  assign upd_match = cmp_vld_q && rd_valid_i && key_eq && !match_found_q;
  assign upd_free  = cmp_vld_q && !rd_valid_i && !free_found_q;
  assign upd_lru   = cmp_vld_q && rd_valid_i && (!lru_found_q || stamp_lt);

  assign gen_zero  = req_q.generation == '0;
  assign hit       = match_found_q && (match_gen_q == req_q.generation);
  assign store_idx = match_found_q ? match_idx_q :
                     (free_found_q ? free_idx_q : lru_idx_q);
  assign clock_inc = clock_q + lkc_pkg::STAMP_W'(1);

  always_comb begin
    state_d     = state_q;
    iss_d       = iss_q;
    cmp_vld_d   = 1'b0;
    req_ready_o = 1'b0;
    rd_en_o     = 1'b0;
    rd_addr_o   = iss_q;
    res_valid_o = 1'b0;
    res_o.status     = lkc_pkg::STAT_MISS;
    res_o.value_out  = '0;
    res_o.slot_index = '0;
    wr_cmd_o    = '0;
    wr_addr_o   = store_idx;
    wr_entry_o.key        = req_q.host_key;
    wr_entry_o.generation = req_q.generation;
    wr_entry_o.handle     = req_q.value_handle;
    wr_entry_o.stamp      = clock_inc;
    clock_d     = clock_q;

    case (state_q)
      lkc_pkg::S_IDLE: begin
        req_ready_o = 1'b1;
        iss_d       = '0;
        if (req_valid_i) begin
          if (req_i.generation == '0 ||
              (req_i.func == lkc_pkg::FUNC_STORE && !req_i.parse_ok)) begin
            state_d = lkc_pkg::S_FIN;
          end else begin
            state_d = lkc_pkg::S_SCAN;
          end
        end
      end
      lkc_pkg::S_SCAN: begin
        rd_en_o   = 1'b1;
        cmp_vld_d = 1'b1;
        if (iss_q == LastIdx) begin
          state_d = lkc_pkg::S_LAST;
        end else begin
          iss_d = iss_q + IdxW'(1);
        end
      end
      lkc_pkg::S_LAST: begin
        state_d = lkc_pkg::S_FIN;
      end
      lkc_pkg::S_FIN: begin
        res_valid_o = 1'b1;
        if (gen_zero) begin
          res_o.status = lkc_pkg::STAT_BADGEN;
        end else if (req_q.func == lkc_pkg::FUNC_LOOKUP) begin
          if (hit) begin
            res_o.status     = lkc_pkg::STAT_HIT;
            res_o.value_out  = match_hdl_q;
            res_o.slot_index = lkc_pkg::SLOT_W'(match_idx_q);
            wr_addr_o        = match_idx_q;
            wr_cmd_o.stamp_we = commit;
            if (commit) begin
              clock_d = clock_inc;
            end
          end
        end else if (!req_q.parse_ok) begin
          res_o.status = lkc_pkg::STAT_DECLINED;
        end else begin
          res_o.status     = lkc_pkg::STAT_STORED;
          res_o.value_out  = req_q.value_handle;
          res_o.slot_index = lkc_pkg::SLOT_W'(store_idx);
          wr_cmd_o.entry_we = commit;
          if (commit) begin
            clock_d = clock_inc;
          end
        end
        if (commit) begin
          state_d = lkc_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = lkc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= lkc_pkg::S_IDLE;
      iss_q     <= '0;
      cmp_vld_q <= 1'b0;
      clock_q   <= '0;
    end else begin
      state_q   <= state_d;
      iss_q     <= iss_d;
      cmp_vld_q <= cmp_vld_d;
      clock_q   <= clock_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    cmp_idx_q <= iss_q;
    if (upd_match) begin
      match_idx_q <= cmp_idx_q;
      match_gen_q <= rd_entry_i.generation;
      match_hdl_q <= rd_entry_i.handle;
    end
    if (upd_free) begin
      free_idx_q <= cmp_idx_q;
    end
    if (upd_lru) begin
      lru_idx_q   <= cmp_idx_q;
      lru_stamp_q <= rd_entry_i.stamp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_found_q <= 1'b0;
      free_found_q  <= 1'b0;
      lru_found_q   <= 1'b0;
    end else if (accept) begin
      match_found_q <= 1'b0;
      free_found_q  <= 1'b0;
      lru_found_q   <= 1'b0;
    end else begin
      if (upd_match) match_found_q <= 1'b1;
      if (upd_free)  free_found_q  <= 1'b1;
      if (upd_lru)   lru_found_q   <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/lru_keyed_cache_with_generation_unit.sv -----
// ----------------------------------------------------------------------------
// LRU keyed cache with generation check - top level
// Fully associative host-key cache with generation match and LRU eviction.
// ----------------------------------------------------------------------------
// A request word (lookup or store) is taken while the sequencer is idle. Words
// with a zero generation, and stores with parse_ok low, are answered at once
// without a scan. Any other word walks every slot through the single table
// read port, one slot a cycle, comparing the key and tracking the first free
// slot and the oldest stamp. Its response then enters the output register, and
// the next word is taken in the same cycle as the response appears there. The
// response sits in an output register, so a new request may be taken while an
// earlier response still waits for rsp_ready_i. The table comes out of reset
// with every slot empty; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "lru_keyed_cache_with_generation_unit_defines.svh"

module lru_keyed_cache_with_generation_unit #(
  parameter int unsigned ENTRIES = lkc_pkg::ENTRIES_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire lkc_pkg::req_t req_i,
  input  wire logic          req_valid_i,
  output logic               req_ready_o,
  output lkc_pkg::rsp_t      rsp_o,
  output logic               rsp_valid_o,
  input  wire logic          rsp_ready_i
);

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // table read / write traffic
  logic             rd_en;
  logic [IdxW-1:0]  rd_addr;
  lkc_pkg::entry_t  rd_entry;
  logic             rd_valid;
  lkc_pkg::wr_cmd_t wr_cmd;
  logic [IdxW-1:0]  wr_addr;
  lkc_pkg::entry_t  wr_entry;

  // sequencer result and the output register in front of it
  lkc_pkg::rsp_t    res;
  logic             res_valid;
  logic             res_ready;
  lkc_pkg::rsp_t    rsp_q;
  logic             rsp_valid_q, rsp_valid_d;

  lkc_table #(
    .Entries (ENTRIES),
    .IdxW    (IdxW)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .rd_entry_o (rd_entry),
    .rd_valid_o (rd_valid),
    .wr_cmd_i   (wr_cmd),
    .wr_addr_i  (wr_addr),
    .wr_entry_i (wr_entry)
  );

  lkc_ctrl #(
    .Entries (ENTRIES),
    .IdxW    (IdxW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .res_o       (res),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_entry_i  (rd_entry),
    .rd_valid_i  (rd_valid),
    .wr_cmd_o    (wr_cmd),
    .wr_addr_o   (wr_addr),
    .wr_entry_o  (wr_entry)
  );

  // Output register: refills whenever empty or being drained this cycle.
  assign res_ready = !rsp_valid_q || rsp_ready_i;

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (res_valid && res_ready) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      rsp_q <= res;
    end
  end

  assign rsp_o       = rsp_q;
  assign rsp_valid_o = rsp_valid_q;

  // One word at a time: after acceptance the sequencer is busy.
  `LKC_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni,
    req_valid_i && req_ready_o, !req_ready_o, "request taken while busy")

  // Misses and rejections carry no handle and no slot.
  `LKC_ASSERT_IMP(a_no_payload_on_fail, clk_i, rst_ni,
    rsp_valid_o && (rsp_o.status == lkc_pkg::STAT_MISS ||
      rsp_o.status == lkc_pkg::STAT_DECLINED || rsp_o.status == lkc_pkg::STAT_BADGEN),
    rsp_o.value_out == '0 && rsp_o.slot_index == '0, "stray payload on failure")

  // A reported slot lies inside the table.
  `LKC_ASSERT_IMP(a_slot_in_range, clk_i, rst_ni,
    rsp_valid_o, {1'b0, rsp_o.slot_index} < (lkc_pkg::SLOT_W + 1)'(ENTRIES),
    "slot index beyond table")

endmodule

`default_nettype wire
